>>> sv/rrd_pkg.sv
// Shared types and constants for the response deframer.
package rrd_pkg;

  localparam logic [7:0] MAGIC_FIRST  = 8'hda;
  localparam logic [7:0] MAGIC_SECOND = 8'hbb;

  localparam int FRONT_DEPTH = 4;
  localparam int FRONT_PTR_W = $clog2(FRONT_DEPTH);
  localparam int FRONT_CNT_W = $clog2(FRONT_DEPTH + 1);

  localparam int RES_DEPTH = 2;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [2:0] FLAGS_LAST = 3'd1;
  localparam logic [2:0] ID_LAST    = 3'd7;
  localparam logic [2:0] LEN_LAST   = 3'd3;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_MAGIC2 = 3'd1,
    PH_FLAGS  = 3'd2,
    PH_ID     = 3'd3,
    PH_LEN    = 3'd4,
    PH_DATA   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_MAGIC1 = 2'd1,
    CLS_MAGIC2 = 2'd2
  } byte_class_e;

  typedef struct packed {
    logic [7:0]  byte_val;
    byte_class_e cls;
  } front_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic [63:0] frame_id;
    logic        last;
  } result_t;

endpackage

>>> sv/rrd_front.sv
// Input byte queue that tags each byte with its magic class.
module rrd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [7:0]           in_byte_i,
  output logic                 full_o,
  output logic                 valid_o,
  output rrd_pkg::front_item_t item_o,
  input  logic                 take_i
);

  rrd_pkg::front_item_t mem_q [rrd_pkg::FRONT_DEPTH];
  logic [rrd_pkg::FRONT_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rrd_pkg::FRONT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;
  rrd_pkg::front_item_t new_item;

  assign full_o  = (cnt_q == rrd_pkg::FRONT_CNT_W'(rrd_pkg::FRONT_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  // classify on the way in so the engine compares a small code
  always_comb begin
    new_item.byte_val = in_byte_i;
    if (in_byte_i == rrd_pkg::MAGIC_FIRST) begin
      new_item.cls = rrd_pkg::CLS_MAGIC1;
    end else if (in_byte_i == rrd_pkg::MAGIC_SECOND) begin
      new_item.cls = rrd_pkg::CLS_MAGIC2;
    end else begin
      new_item.cls = rrd_pkg::CLS_OTHER;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + rrd_pkg::FRONT_PTR_W'(do_push);
    rd_ptr_d = rd_ptr_q + rrd_pkg::FRONT_PTR_W'(do_pop);
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + rrd_pkg::FRONT_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - rrd_pkg::FRONT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

>>> sv/rrd_engine.sv
// Frame state machine: header parsing, id and length capture, payload tagging.
module rrd_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 front_valid_i,
  input  rrd_pkg::front_item_t front_item_i,
  output logic                 front_take_o,
  input  logic                 res_space_i,
  output logic                 res_push_o,
  output rrd_pkg::result_t     res_item_o
);

  rrd_pkg::phase_e phase_q, phase_d;
  logic [2:0]      hdr_cnt_q, hdr_cnt_d;
  logic [63:0]     id_q, id_d;
  logic [31:0]     rem_q, rem_d;
  logic            step;
  logic [7:0]      b;
  logic [31:0]     len_next;
  logic [31:0]     rem_dec;

  assign step         = front_valid_i && res_space_i;
  assign front_take_o = step;
  assign b            = front_item_i.byte_val;
  assign len_next     = {rem_q[23:0], b};
  assign rem_dec      = rem_q - 32'd1;

  // next state
  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    id_d      = id_q;
    rem_d     = rem_q;
    if (step) begin
      case (phase_q)
        rrd_pkg::PH_MAGIC2: begin
          if (front_item_i.cls == rrd_pkg::CLS_MAGIC2) begin
            phase_d   = rrd_pkg::PH_FLAGS;
            hdr_cnt_d = '0;
          end else if (front_item_i.cls == rrd_pkg::CLS_MAGIC1) begin
            phase_d = rrd_pkg::PH_MAGIC2;
          end else begin
            phase_d = rrd_pkg::PH_HUNT;
          end
        end
        rrd_pkg::PH_FLAGS: begin
          if (hdr_cnt_q >= rrd_pkg::FLAGS_LAST) begin
            phase_d   = rrd_pkg::PH_ID;
            hdr_cnt_d = '0;
            id_d      = '0;
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        rrd_pkg::PH_ID: begin
          id_d = {id_q[55:0], b};
          if (hdr_cnt_q >= rrd_pkg::ID_LAST) begin
            phase_d   = rrd_pkg::PH_LEN;
            hdr_cnt_d = '0;
            rem_d     = '0;
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        rrd_pkg::PH_LEN: begin
          rem_d = len_next;
          if (hdr_cnt_q >= rrd_pkg::LEN_LAST) begin
            hdr_cnt_d = '0;
            phase_d   = (len_next == '0) ? rrd_pkg::PH_HUNT : rrd_pkg::PH_DATA;
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        rrd_pkg::PH_DATA: begin
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = rrd_pkg::PH_HUNT;
          end
        end
        default: begin
          phase_d = (front_item_i.cls == rrd_pkg::CLS_MAGIC1) ? rrd_pkg::PH_MAGIC2
                                                               : rrd_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res_push_o           = 1'b0;
    res_item_o.data_byte = '0;
    res_item_o.has_data  = 1'b0;
    res_item_o.frame_id  = id_q;
    res_item_o.last      = 1'b1;
    case (phase_q)
      rrd_pkg::PH_LEN: begin
        res_push_o = step && (hdr_cnt_q >= rrd_pkg::LEN_LAST) && (len_next == '0);
      end
      rrd_pkg::PH_DATA: begin
        res_push_o           = step;
        res_item_o.data_byte = b;
        res_item_o.has_data  = 1'b1;
        res_item_o.last      = (rem_dec == '0);
      end
      default: begin
        res_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rrd_pkg::PH_HUNT;
      hdr_cnt_q <= '0;
      id_q      <= '0;
      rem_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      id_q      <= id_d;
      rem_q     <= rem_d;
    end
  end

endmodule

>>> sv/rrd_res_queue.sv
// Result queue that holds finished items until the consumer pops them.
module rrd_res_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rrd_pkg::result_t item_i,
  output logic             space_o,
  input  logic             pop_i,
  output logic             empty_o,
  output rrd_pkg::result_t head_o
);

  rrd_pkg::result_t mem_q [rrd_pkg::RES_DEPTH];
  logic [rrd_pkg::RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [rrd_pkg::RES_CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  // a slot frees up in the same cycle as a pop
  assign space_o = (cnt_q != rrd_pkg::RES_CNT_W'(rrd_pkg::RES_DEPTH)) || do_pop;
  assign do_push = push_i && space_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + rrd_pkg::RES_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - rrd_pkg::RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + rrd_pkg::RES_PTR_W'(do_push);
      rd_ptr_q <= rd_ptr_q + rrd_pkg::RES_PTR_W'(do_pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> sv/rpc_response_deframer_core.sv
// Top level of the response frame deframer.
//
//   channel   direction  handshake          payload
//   input     in         push_i / full_o    in_byte_i
//   result    out        pop_i / empty_o    data_byte_o, has_data_o, frame_id_o, last_o
//
// Sustained rate is one byte per cycle while results are popped: the engine steps once
// per byte and the result queue frees a slot in the same cycle it is popped.
// An accepted byte is registered in the front queue; the engine steps on it at the head of
// that queue and writes the result queue, whose head drives the result ports.
// Reset clears both queues and returns the engine to hunting for the first magic byte.
// When results are not popped the engine holds once the two-entry result queue fills;
// the four-entry front queue then absorbs bytes until full_o rises.
module rpc_response_deframer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [7:0]  in_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  data_byte_o,
  output logic        has_data_o,
  output logic [63:0] frame_id_o,
  output logic        last_o
);

  logic                 front_valid;
  logic                 front_take;
  rrd_pkg::front_item_t front_item;
  logic                 res_space;
  logic                 res_push;
  rrd_pkg::result_t     res_item;
  rrd_pkg::result_t     res_head;

  // front: take bytes and tag magic codes
  rrd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .in_byte_i (in_byte_i),
    .full_o    (full_o),
    .valid_o   (front_valid),
    .item_o    (front_item),
    .take_i    (front_take)
  );

  // back: advance the frame state one byte per step, hold while no result slot
  rrd_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .front_valid_i (front_valid),
    .front_item_i  (front_item),
    .front_take_o  (front_take),
    .res_space_i   (res_space),
    .res_push_o    (res_push),
    .res_item_o    (res_item)
  );

  // result queue: decouple the engine from the consumer
  rrd_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_item),
    .space_o (res_space),
    .pop_i   (pop_i),
    .empty_o (empty_o),
    .head_o  (res_head)
  );

  assign data_byte_o = res_head.data_byte;
  assign has_data_o  = res_head.has_data;
  assign frame_id_o  = res_head.frame_id;
  assign last_o      = res_head.last;

endmodule

>>> sv/rrd_checker.sv
// Port-level checks for the response deframer, bound to the top level.
module rrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push_i,
  input logic        full_o,
  input logic [7:0]  in_byte_i,
  input logic        empty_o,
  input logic        pop_i,
  input logic [7:0]  data_byte_o,
  input logic        has_data_o,
  input logic [63:0] frame_id_o,
  input logic        last_o
);

  // a waiting result stays until popped
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(data_byte_o) && $stable(has_data_o)
                              && $stable(frame_id_o) && $stable(last_o)))
    else $error("result changed while stalled");

  // an empty completion is always marked last and carries no byte
  a_empty_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !has_data_o) |-> (last_o && (data_byte_o == 8'd0)))
    else $error("empty completion malformed");

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> (empty_o && !full_o))
    else $error("queues not empty after reset");

  // the input queue fills only on an accepted item
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i && !full_o))
    else $error("full rose without an accepted item");

  // an accepted item carries a known byte
  a_push_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |-> !$isunknown(in_byte_i))
    else $error("unknown byte accepted");

endmodule

bind rpc_response_deframer_core rrd_checker u_rrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push_i      (push_i),
  .full_o      (full_o),
  .in_byte_i   (in_byte_i),
  .empty_o     (empty_o),
  .pop_i       (pop_i),
  .data_byte_o (data_byte_o),
  .has_data_o  (has_data_o),
  .frame_id_o  (frame_id_o),
  .last_o      (last_o)
);

>>> tb/tb_rpc_response_deframer_core.sv
// Self-checking testbench for the response frame deframer core.
module tb_rpc_response_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  // Track the deframer state and hold the results it owes, oldest first.
  class frame_tracker;
    rrd_pkg::phase_e  phase;
    logic [2:0]       hdr_cnt;
    logic [63:0]      id_sr;
    logic [31:0]      remain;
    rrd_pkg::result_t owed_q[$];
    int               errors;
    int               payload_cnt;
    int               empty_cnt;
    int               last_cnt;

    function new();
      phase       = rrd_pkg::PH_HUNT;
      hdr_cnt     = 3'd0;
      id_sr       = 64'd0;
      remain      = 32'd0;
      errors      = 0;
      payload_cnt = 0;
      empty_cnt   = 0;
      last_cnt    = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Step the state on one accepted item and queue any result it causes.
    function void take_byte(logic [7:0] b);
      rrd_pkg::result_t r;
      r = '0;
      case (phase)
        rrd_pkg::PH_MAGIC2: begin
          if (b == rrd_pkg::MAGIC_SECOND) begin
            phase   = rrd_pkg::PH_FLAGS;
            hdr_cnt = 3'd0;
          end else if (b == rrd_pkg::MAGIC_FIRST) begin
            phase = rrd_pkg::PH_MAGIC2;
          end else begin
            phase = rrd_pkg::PH_HUNT;
          end
        end
        rrd_pkg::PH_FLAGS: begin
          if (hdr_cnt >= rrd_pkg::FLAGS_LAST) begin
            phase   = rrd_pkg::PH_ID;
            hdr_cnt = 3'd0;
            id_sr   = 64'd0;
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
        rrd_pkg::PH_ID: begin
          id_sr = {id_sr[55:0], b};
          if (hdr_cnt >= rrd_pkg::ID_LAST) begin
            phase   = rrd_pkg::PH_LEN;
            hdr_cnt = 3'd0;
            remain  = 32'd0;
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
        rrd_pkg::PH_LEN: begin
          remain = {remain[23:0], b};
          if (hdr_cnt >= rrd_pkg::LEN_LAST) begin
            hdr_cnt = 3'd0;
            if (remain == 32'd0) begin
              phase       = rrd_pkg::PH_HUNT;
              r.data_byte = 8'h00;
              r.has_data  = 1'b0;
              r.frame_id  = id_sr;
              r.last      = 1'b1;
              owed_q.push_back(r);
            end else begin
              phase = rrd_pkg::PH_DATA;
            end
          end else begin
            hdr_cnt = hdr_cnt + 3'd1;
          end
        end
        rrd_pkg::PH_DATA: begin
          remain      = remain - 32'd1;
          r.data_byte = b;
          r.has_data  = 1'b1;
          r.frame_id  = id_sr;
          r.last      = (remain == 32'd0);
          owed_q.push_back(r);
          if (remain == 32'd0) phase = rrd_pkg::PH_HUNT;
        end
        default: begin
          phase = (b == rrd_pkg::MAGIC_FIRST) ? rrd_pkg::PH_MAGIC2 : rrd_pkg::PH_HUNT;
        end
      endcase
    endfunction

    // Compare one popped result against the oldest owed one.
    function void check_result(rrd_pkg::result_t got);
      rrd_pkg::result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result data=%h has_data=%b id=%h last=%b", $time,
                 got.data_byte, got.has_data, got.frame_id, got.last);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $display("%0t: data_byte expected %h actual %h", $time, want.data_byte, got.data_byte);
        errors++;
      end
      if (got.has_data !== want.has_data) begin
        $display("%0t: has_data expected %b actual %b", $time, want.has_data, got.has_data);
        errors++;
      end
      if (got.frame_id !== want.frame_id) begin
        $display("%0t: frame_id expected %h actual %h", $time, want.frame_id, got.frame_id);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (want.has_data) payload_cnt++;
      else empty_cnt++;
      if (want.last) last_cnt++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push_r;
  logic [7:0]  in_byte_r;
  logic        pop_r;
  logic        full_o;
  logic        empty_o;
  logic [7:0]  data_byte_o;
  logic        has_data_o;
  logic [63:0] frame_id_o;
  logic        last_o;

  frame_tracker tracker;

  // Idling knobs, set by the stimulus and read by the drivers, and a sent-byte count.
  int sender_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int bytes_sent;

  rpc_response_deframer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_r),
    .full_o      (full_o),
    .in_byte_i   (in_byte_r),
    .empty_o     (empty_o),
    .pop_i       (pop_r),
    .data_byte_o (data_byte_o),
    .has_data_o  (has_data_o),
    .frame_id_o  (frame_id_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  initial begin
    #2_000_000;
    $display("[rpc_response_deframer_core] ERROR");
    $finish;
  end

  // Receiver: pop at random, or hold pop low for a requested number of cycles.
  initial begin
    pop_r = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        pop_r <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        pop_r <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: sample both handshakes on the pre-edge values.
  always @(posedge clk_i) begin
    rrd_pkg::result_t got;
    if (rst_ni) begin
      if (pop_r && !empty_o) begin
        got.data_byte = data_byte_o;
        got.has_data  = has_data_o;
        got.frame_id  = frame_id_o;
        got.last      = last_o;
        tracker.check_result(got);
      end
      if (push_r && !full_o) tracker.take_byte(in_byte_r);
    end
  end

  // Offer one item after a random gap; return at the edge that accepts it.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      push_r <= 1'b0;
      @(posedge clk_i);
    end
    push_r    <= 1'b1;
    in_byte_r <= b;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Draw a payload byte; salt it with magic values now and then.
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(7))
      0:       return rrd_pkg::MAGIC_FIRST;
      1:       return rrd_pkg::MAGIC_SECOND;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Send a full header followed by n_payload payload items.
  task automatic send_frame(input logic [7:0] flag0, input logic [7:0] flag1,
                            input logic [63:0] id, input logic [31:0] len,
                            input int n_payload);
    send_byte(rrd_pkg::MAGIC_FIRST);
    send_byte(rrd_pkg::MAGIC_SECOND);
    send_byte(flag0);
    send_byte(flag1);
    for (int i = 7; i >= 0; i--) send_byte(id[i*8 +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(len[i*8 +: 8]);
    for (int i = 0; i < n_payload; i++) send_byte(payload_byte());
  endtask

  // Lower push and hold until every owed result has been popped.
  task automatic drain();
    push_r <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Random traffic: mostly clean frames, some stray bytes and broken magic.
  task automatic random_traffic(input int idle_pct, input int stall_pct, input int n_bytes);
    int          stop_at;
    int          pick;
    int          len;
    logic [63:0] id;
    stop_at         = bytes_sent + n_bytes;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        pick = $urandom_range(99);
        if (pick < 6) len = 0;
        else if (pick < 80) len = $urandom_range(8, 1);
        else if (pick < 98) len = $urandom_range(48, 9);
        else len = 256;
        id = {32'($urandom), 32'($urandom)};
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), id, len, len);
      end else if (pick < 84) begin
        // Drop a few stray items; any value, a lone first magic included.
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end else begin
        // Break the magic: first magic, maybe repeated, then a wrong second byte.
        send_byte(rrd_pkg::MAGIC_FIRST);
        if ($urandom_range(1)) send_byte(rrd_pkg::MAGIC_FIRST);
        do pick = $urandom_range(255); while (pick == rrd_pkg::MAGIC_SECOND);
        send_byte(8'(pick));
      end
    end
    drain();
  endtask

  initial begin
    tracker         = new();
    rst_ni          = 1'b0;
    push_r          = 1'b0;
    in_byte_r       = 8'h00;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 0;
    bytes_sent      = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: stray bytes while hunting, a bad second magic, a repeated
    // first magic, magic values in the flags, an empty frame with all-ones id.
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(rrd_pkg::MAGIC_SECOND);
    send_byte(rrd_pkg::MAGIC_FIRST);
    send_byte(8'h12);
    send_byte(rrd_pkg::MAGIC_FIRST);
    send_frame(rrd_pkg::MAGIC_FIRST, rrd_pkg::MAGIC_SECOND, 64'hffff_ffff_ffff_ffff,
               32'd0, 0);
    // Directed: zero id, two payload items at the byte extremes.
    send_byte(rrd_pkg::MAGIC_FIRST);
    send_byte(rrd_pkg::MAGIC_SECOND);
    for (int i = 0; i < 14; i++) send_byte((i == 13) ? 8'd2 : 8'd0);
    send_byte(8'hff);
    send_byte(8'h00);
    drain();

    random_traffic(0, 0, 250);
    random_traffic(78, 0, 250);
    random_traffic(0, 78, 250);
    random_traffic(31, 31, 250);

    // Back-pressure: hold pop off for a long stretch while pushing a long frame
    // back to back, so both queues fill and full_o rises.
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_cycles     = 120;
    send_frame(8'h00, 8'h00, {32'($urandom), 32'($urandom)}, 32'd48, 48);
    push_r <= 1'b0;
    @(posedge clk_i);
    while (hold_cycles != 0) @(posedge clk_i);
    drain();
    repeat (20) @(posedge clk_i);

    // Leave a frame with the largest length open; only its first items arrive.
    recv_stall_pct = 31;
    send_frame(8'hff, 8'hff, {32'($urandom), 32'($urandom)}, 32'hffff_ffff, 40);
    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes; checked %0d payload results and %0d empty frames, %0d ends.",
             bytes_sent, tracker.payload_cnt, tracker.empty_cnt, tracker.last_cnt);
    $display("Covered stray bytes, broken magic, back-pressure and four idling mixes.");
    if (tracker.errors == 0) begin
      $display("[rpc_response_deframer_core] OK");
    end else begin
      $display("[rpc_response_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
